// ===== hw/rtl/dpi_pkg.sv =====
// Shared types and encodings for the AArch64 data-processing immediate block.
// Used by dpi_decode, dpi_exec and the top level. No dependencies.
package dpi_pkg;

  // Result status codes
  localparam logic [1:0] ST_EXEC    = 2'd0;
  localparam logic [1:0] ST_UNALLOC = 2'd1;
  localparam logic [1:0] ST_UNSUP   = 2'd2;

  // Data-processing immediate group codes (instruction bits 25..23)
  localparam logic [2:0] GRP_ADDSUB = 3'd2;
  localparam logic [2:0] GRP_LOGIC  = 3'd4;
  localparam logic [2:0] GRP_MOVW   = 3'd5;

  // Logical opc field
  localparam logic [1:0] LOG_AND  = 2'd0;
  localparam logic [1:0] LOG_ORR  = 2'd1;
  localparam logic [1:0] LOG_EOR  = 2'd2;
  localparam logic [1:0] LOG_ANDS = 2'd3;

  // Move wide opc field
  localparam logic [1:0] MOV_N   = 2'd0;
  localparam logic [1:0] MOV_RSV = 2'd1;
  localparam logic [1:0] MOV_Z   = 2'd2;
  localparam logic [1:0] MOV_K   = 2'd3;

  localparam logic [63:0] LOW32_MASK = 64'h0000_0000_ffff_ffff;

  typedef enum logic [1:0] {
    OPK_NONE   = 2'd0,
    OPK_ADDSUB = 2'd1,
    OPK_LOGIC  = 2'd2,
    OPK_MOVW   = 2'd3
  } op_kind_t;

  // Decoded request passed from the front end to the execute side
  typedef struct packed {
    op_kind_t    kind;
    logic [1:0]  status;
    logic        wide;
    logic        sub;
    logic        setf;
    logic [1:0]  opc;
    logic [1:0]  hw;
    logic [4:0]  rd;
    logic [4:0]  rsrc;
    logic [63:0] operand;
  } dec_t;

  // One result item
  typedef struct packed {
    logic [1:0]  status;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [63:0] dest_value;
    logic        flags_written;
    logic [3:0]  nzcv;
  } res_t;

endpackage

// ===== hw/rtl/dpi_fifo.sv =====
// Small synchronous FIFO with registered storage and full/empty flags.
// Generic; no package dependency.
module dpi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULLCNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULLCNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == LAST) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == LAST) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/dpi_decode.sv =====
// Front end: classifies an instruction word and builds its immediate operand,
// including the bitmask-immediate decode. Depends on dpi_pkg.
module dpi_decode (
  input  logic [31:0]  instr,
  output dpi_pkg::dec_t dec
);
  import dpi_pkg::*;

  logic       is_dpi, wide, nbit, reserved;
  logic [2:0] grp;
  logic [5:0] imms, immr, levels, s, r, idx;
  logic [6:0] combo;
  logic [63:0] elem, rep, mask, movimm;
  logic [127:0] dbl;
  logic [11:0] imm12;

  assign is_dpi = (instr[28:26] == 3'b100);
  assign grp    = instr[25:23];
  assign wide   = instr[31];
  assign nbit   = instr[22];
  assign imms   = instr[15:10];
  assign immr   = instr[21:16];
  assign imm12  = instr[21:10];
  assign combo  = {nbit, ~imms};
  assign movimm = {48'd0, instr[20:5]} << {instr[22:21], 4'd0};

  // Bitmask immediate: element size from the highest set bit of {N, ~imms},
  // a run of s+1 ones, replicated across 64 bits, then rotated right by r
  // (rotating the replicated word equals rotating each element).
  always_comb begin
    levels   = 6'd0;
    reserved = 1'b0;
    if (combo[6])      levels = 6'd63;
    else if (combo[5]) levels = 6'd31;
    else if (combo[4]) levels = 6'd15;
    else if (combo[3]) levels = 6'd7;
    else if (combo[2]) levels = 6'd3;
    else if (combo[1]) levels = 6'd1;
    else               reserved = 1'b1;
    s = imms & levels;
    r = immr & levels;
    if (s == levels) reserved = 1'b1;
    elem = (64'd1 << ({1'b0, s} + 7'd1)) - 64'd1;
    for (int i = 0; i < 64; i++) begin
      idx    = 6'(i) & levels;
      rep[i] = elem[idx];
    end
    dbl  = {rep, rep} >> r;
    mask = dbl[63:0];
  end

  always_comb begin
    dec         = '0;
    dec.kind    = OPK_NONE;
    dec.status  = ST_UNSUP;
    dec.wide    = wide;
    dec.sub     = instr[30];
    dec.setf    = instr[29];
    dec.opc     = instr[30:29];
    dec.hw      = instr[22:21];
    dec.rd      = instr[4:0];
    dec.rsrc    = instr[9:5];
    dec.operand = '0;
    if (is_dpi) begin
      case (grp)
        GRP_ADDSUB: begin
          dec.kind    = OPK_ADDSUB;
          dec.status  = ST_EXEC;
          dec.operand = nbit ? {40'd0, imm12, 12'd0} : {52'd0, imm12};
        end
        GRP_LOGIC: begin
          if ((!wide && nbit) || reserved) begin
            dec.status = ST_UNALLOC;
          end else begin
            dec.kind    = OPK_LOGIC;
            dec.status  = ST_EXEC;
            dec.operand = mask;
          end
        end
        GRP_MOVW: begin
          if (instr[30:29] == MOV_RSV || (!wide && instr[22])) begin
            dec.status = ST_UNALLOC;
          end else begin
            dec.kind    = OPK_MOVW;
            dec.status  = ST_EXEC;
            dec.rsrc    = instr[4:0];  // MOVK merges into the old Rd
            dec.operand = movimm;
          end
        end
        default: begin
          dec.status = ST_UNSUP;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/dpi_exec.sv =====
// Back end: register file, NZCV flags and the combinational execute datapath.
// Takes decoded requests, produces result items. Depends on dpi_pkg.
module dpi_exec (
  input  logic          clk,
  input  logic          rst_n,
  input  dpi_pkg::dec_t dec,
  input  logic          dec_empty,
  output logic          dec_pop,
  input  logic          res_full,
  output logic          res_push,
  output dpi_pkg::res_t res
);
  import dpi_pkg::*;

  logic [63:0] rf_r [32];
  logic [3:0]  flags_r, flags_nxt;
  logic        fire, wrote, fl;
  logic [63:0] x, y, value, hwmask, lres;
  logic [64:0] sum;
  logic        c32;
  logic [3:0]  fset;

  assign fire     = !dec_empty && !res_full;
  assign dec_pop  = fire;
  assign res_push = fire;
  assign x        = rf_r[dec.rsrc];
  assign y        = dec.sub ? ~dec.operand : dec.operand;
  assign sum      = {1'b0, x} + {1'b0, y} + {64'd0, dec.sub};
  assign c32      = x[32] ^ y[32] ^ sum[32];   // carry out of bit 31
  assign hwmask   = {48'd0, 16'hffff} << {dec.hw, 4'd0};

  always_comb begin
    value = '0;
    wrote = 1'b0;
    fl    = 1'b0;
    fset  = flags_r;
    lres  = '0;
    case (dec.kind)
      OPK_ADDSUB: begin
        wrote = 1'b1;
        fl    = dec.setf;
        if (dec.wide) begin
          value = sum[63:0];
          fset  = {value[63], value == 64'd0, sum[64],
                   x[63] ^ value[63] & ~(x[63] ^ y[63]) ^ x[63] & 1'b0};
          fset[0] = ((x[63] ^ value[63]) & (y[63] ^ value[63]));
        end else begin
          value = {32'd0, sum[31:0]};
          fset  = {value[31], value == 64'd0, c32,
                   (x[31] ^ value[31]) & (y[31] ^ value[31])};
        end
      end
      OPK_LOGIC: begin
        wrote = 1'b1;
        fl    = (dec.opc == LOG_ANDS);
        case (dec.opc)
          LOG_ORR: lres = x | dec.operand;
          LOG_EOR: lres = x ^ dec.operand;
          default: lres = x & dec.operand;
        endcase
        value = dec.wide ? lres : (lres & LOW32_MASK);
        fset  = {dec.wide ? value[63] : value[31], value == 64'd0, 2'b00};
      end
      OPK_MOVW: begin
        wrote = 1'b1;
        case (dec.opc)
          MOV_N:   lres = ~dec.operand;
          MOV_Z:   lres = dec.operand;
          default: lres = (x & ~hwmask) | dec.operand;
        endcase
        value = dec.wide ? lres : (lres & LOW32_MASK);
      end
      default: begin
        wrote = 1'b0;
      end
    endcase
  end

  assign flags_nxt = (fire && fl) ? fset : flags_r;

  always_comb begin
    res.status        = dec.status;
    res.reg_written   = wrote;
    res.dest_index    = wrote ? dec.rd : 5'd0;
    res.dest_value    = wrote ? value : 64'd0;
    res.flags_written = fl;
    res.nzcv          = flags_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      for (int i = 0; i < 32; i++) begin
        rf_r[i] <= '0;
      end
    end else begin
      flags_r <= flags_nxt;
      if (fire && wrote) begin
        rf_r[dec.rd] <= value;
      end
    end
  end

endmodule

// ===== hw/rtl/aarch64_dp_immediate_execute.sv =====
// Top level of the AArch64 data-processing immediate execute block.
// Instantiates dpi_decode, two dpi_fifo queues and dpi_exec; uses dpi_pkg.
//
// Usage: push one 32-bit instruction word per request on the input queue
// port; each one yields exactly one result on the output queue port, in
// order. Add/subtract, logical (bitmask) and move-wide immediates are
// executed against a 32 x 64-bit register file and the NZCV flags, all
// zero after reset; register 31 is a normal register. Throughput is one
// instruction per cycle while the result queue is not full: the execute
// unit reads and computes combinationally and writes back the register
// file and flags as the request is popped, so dependent instructions need
// no stall. Decode writes the request queue when a word is accepted,
// execute writes the result queue when it pops the request, and the
// result can then be popped from the result queue. Both queues are
// QUEUE_DEPTH / OUT_DEPTH deep, so the input keeps flowing while a result
// waits, and full rises only once both queues have backed up.
module aarch64_dp_immediate_execute #(
  parameter int QUEUE_DEPTH = 2,
  parameter int OUT_DEPTH   = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_instruction,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_status,
  output logic        out_reg_written,
  output logic [4:0]  out_dest_index,
  output logic [63:0] out_dest_value,
  output logic        out_flags_written,
  output logic [3:0]  out_nzcv
);
  import dpi_pkg::*;

  dec_t dec_in, dec_head;
  res_t res_in, res_head;
  logic dec_empty, dec_pop, res_full, res_push;

  // Front end: decode straight into the request queue
  dpi_decode u_decode (
    .instr (in_instruction),
    .dec   (dec_in)
  );

  dpi_fifo #(
    .WIDTH ($bits(dec_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_dec_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (dec_in),
    .full  (full),
    .pop   (dec_pop),
    .rdata (dec_head),
    .empty (dec_empty)
  );

  // Back end: execute the oldest decoded request when there is result room
  dpi_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec       (dec_head),
    .dec_empty (dec_empty),
    .dec_pop   (dec_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  dpi_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign out_status        = res_head.status;
  assign out_reg_written   = res_head.reg_written;
  assign out_dest_index    = res_head.dest_index;
  assign out_dest_value    = res_head.dest_value;
  assign out_flags_written = res_head.flags_written;
  assign out_nzcv          = res_head.nzcv;

endmodule
